/* hdl/mtbg_pkg.sv */
// Shared types and constants for the mesh tangent basis generator.
package mtbg_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_TRI  = 2'd1,
        REQ_FIN  = 2'd2,
        REQ_NONE = 2'd3
    } req_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARD,
        ST_ACAP,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_ELEM,
        ST_DIVS,
        ST_DIVW,
        ST_SQRT,
        ST_SQRTW,
        ST_SRD,
        ST_SCAP,
        ST_EMIT
    } state_t;

    // Arithmetic phases of the sequencer
    typedef enum logic [2:0] {
        PH_DET,
        PH_TNUM,
        PH_DOT,
        PH_VEC,
        PH_LEN,
        PH_RES,
        PH_CROSS,
        PH_HAND
    } phase_t;

    // Status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    // Configuration register indexes
    localparam logic CFG_DET_THR  = 1'b0;
    localparam logic CFG_NULL_THR = 1'b1;

    // Divider datapath width and step count (overflow check plus 32 quotient bits)
    localparam int DIV_W      = 97;
    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 32;

endpackage

/* hdl/mesh_tangent_basis_generator_core.sv */
// Top level: vertex and sum memories, shared multiplier, sequencer and output register.
// A load leaves the sequencer idle. A triangle skips its quotients when the determinant is degenerate.
// A finalize skips its quotients on fallback, and waits for the output register to drain.
// A quotient ends early when it overflows.
// One item at a time; a waiting result does not block a following load or triangle.
// Reset clears control and thresholds (both to 1); memories are not cleared.
module mesh_tangent_basis_generator_core
    import mtbg_pkg::*;
#(
    parameter int VERTEX_DEPTH = 4096,
    parameter int FRAC_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // index_a[11:0] index_b[23:12] index_c[35:24] pos_x..z[131:36]
    // tex_u,v[195:132] norm_x..z[291:196] zero[295:292]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [295:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
    // vertex_index[11:0] tangent_x[43:12] tangent_y[75:44] tangent_z[107:76] zero[111:108]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // handed_negative[0] used_fallback[1]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int AW = $clog2(VERTEX_DEPTH);
    localparam logic [31:0] FX_ONE = 32'd1 << FRAC_BITS;

    // Saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > $signed(64'h0000_0000_7FFF_FFFF))
        begin
            return 32'h7FFF_FFFF;
        end
        else if (v < $signed(64'hFFFF_FFFF_8000_0000))
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
        return sat32(64'($signed(a)) + 64'($signed(b)));
    endfunction

    function automatic logic [31:0] sub_sat(input logic [31:0] a, input logic [31:0] b);
        return sat32(64'($signed(a)) - 64'($signed(b)));
    endfunction

    // Index of the last product term in each phase
    function automatic logic [1:0] last_term(input phase_t ph);
        case (ph)
            PH_DOT, PH_LEN, PH_HAND: return 2'd2;
            PH_DET, PH_TNUM, PH_CROSS: return 2'd1;
            default: return 2'd0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    req_t   req_reg;
    logic [1:0] k_reg, k_next;
    logic [2:0] j_reg, j_next;
    logic [1:0] m_reg, m_next;

    logic [15:0] det_thr_reg;
    logic [15:0] null_thr_reg;

    logic [11:0] idx_reg [3];
    logic [31:0] pos_reg [3][3];
    logic [31:0] tex_reg [3][2];
    logic [31:0] n_reg [3];
    logic [31:0] t_reg [3];
    logic [31:0] b_reg [3];
    logic [31:0] q1_reg [3];
    logic [31:0] q2_reg [3];
    logic [31:0] v_reg [3];
    logic [31:0] c_reg [3];
    logic [31:0] tg_reg [3];
    logic [31:0] bt_reg [3];
    logic [31:0] s1_reg, s2_reg, t1_reg, t2_reg, d_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] det_reg;
    logic [63:0] len2_reg;
    logic [31:0] len_reg;
    logic        fb_reg;

    logic        out_valid_reg;
    logic [11:0] out_index_reg;
    logic [31:0] out_tan_reg [3];
    logic        out_neg_reg;
    logic        out_fb_reg;

    // ---------------------------------------------------------------
    // Input decode
    // ---------------------------------------------------------------
    req_t        in_req;
    logic [11:0] in_ia, in_ib, in_ic;
    logic        in_accept;
    logic        ia_ok, ib_ok, ic_ok;
    logic        load_we;

    assign in_req    = req_t'(s_axis_tuser);
    assign in_ia     = s_axis_tdata[11:0];
    assign in_ib     = s_axis_tdata[23:12];
    assign in_ic     = s_axis_tdata[35:24];
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign ia_ok     = 32'(in_ia) < VERTEX_DEPTH;
    assign ib_ok     = 32'(in_ib) < VERTEX_DEPTH;
    assign ic_ok     = 32'(in_ic) < VERTEX_DEPTH;
    assign load_we   = in_accept && (in_req == REQ_LOAD) && ia_ok;

    // ---------------------------------------------------------------
    // Memories
    // ---------------------------------------------------------------
    logic [AW-1:0]  attr_waddr, rd_addr, sum_waddr;
    logic [255:0]   attr_rdata;
    logic [191:0]   sum_rdata, sum_wdata, sum_upd;
    logic           sum_we;

    assign attr_waddr = AW'(in_ia);
    assign rd_addr    = AW'(idx_reg[k_reg]);
    assign sum_we     = load_we || (state_reg == ST_SCAP);
    assign sum_waddr  = load_we ? AW'(in_ia) : AW'(idx_reg[k_reg]);
    assign sum_wdata  = load_we ? '0 : sum_upd;

    mtbg_ram #(
        .DEPTH(VERTEX_DEPTH),
        .WIDTH(256)
    ) u_attr_ram (
        .clk  (clk),
        .we   (load_we),
        .waddr(attr_waddr),
        .wdata(s_axis_tdata[291:36]),
        .raddr(rd_addr),
        .rdata(attr_rdata)
    );

    mtbg_ram #(
        .DEPTH(VERTEX_DEPTH),
        .WIDTH(192)
    ) u_sum_ram (
        .clk  (clk),
        .we   (sum_we),
        .waddr(sum_waddr),
        .wdata(sum_wdata),
        .raddr(rd_addr),
        .rdata(sum_rdata)
    );

    // Saturating add of the triangle's frame into one vertex's sums
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum_upd[32*i +: 32]     = add_sat(sum_rdata[32*i +: 32], tg_reg[i]);
            sum_upd[96 + 32*i +: 32] = add_sat(sum_rdata[96 + 32*i +: 32], bt_reg[i]);
        end
    end

    // ---------------------------------------------------------------
    // Iterative units
    // ---------------------------------------------------------------
    logic               div_start, sqrt_start;
    logic signed [63:0] div_num, div_den;
    logic [31:0]        div_quot, sqrt_root;
    unit_stat_t         div_stat, sqrt_stat;

    mtbg_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (div_num),
        .den  (div_den),
        .quot (div_quot),
        .stat (div_stat)
    );

    mtbg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .radicand(len2_reg),
        .root    (sqrt_root),
        .stat    (sqrt_stat)
    );

    // ---------------------------------------------------------------
    // Multiplier operand select and accumulate
    // ---------------------------------------------------------------
    logic signed [31:0] opa, opb;
    logic               op_sub, op_raw;
    logic signed [63:0] op_base, term, acc_base, acc_next;
    logic [1:0]         jj, kk, jn1, jn2;
    logic               det_degen, fb_now, last_m;
    logic [63:0]        det_abs;

    assign jj  = j_reg[1:0];
    assign kk  = (j_reg >= 3'd3) ? 2'(j_reg - 3'd3) : jj;
    assign jn1 = (jj == 2'd0) ? 2'd1 : ((jj == 2'd1) ? 2'd2 : 2'd0);
    assign jn2 = (jj == 2'd0) ? 2'd2 : ((jj == 2'd1) ? 2'd0 : 2'd1);

    always_comb
    begin
        opa     = '0;
        opb     = '0;
        op_sub  = 1'b0;
        op_raw  = 1'b0;
        op_base = '0;
        case (phase_reg)
            PH_DET:
            begin
                opa    = (m_reg == 2'd0) ? s1_reg : s2_reg;
                opb    = (m_reg == 2'd0) ? t2_reg : t1_reg;
                op_sub = (m_reg != 2'd0);
            end
            PH_TNUM:
            begin
                if (j_reg < 3'd3)
                begin
                    opa = (m_reg == 2'd0) ? t2_reg : t1_reg;
                    opb = (m_reg == 2'd0) ? q1_reg[kk] : q2_reg[kk];
                end
                else
                begin
                    opa = (m_reg == 2'd0) ? s1_reg : s2_reg;
                    opb = (m_reg == 2'd0) ? q2_reg[kk] : q1_reg[kk];
                end
                op_sub = (m_reg != 2'd0);
            end
            PH_DOT:
            begin
                opa = n_reg[m_reg];
                opb = t_reg[m_reg];
            end
            PH_VEC:
            begin
                opa     = n_reg[jj];
                opb     = d_reg;
                op_sub  = 1'b1;
                op_base = 64'($signed(t_reg[jj]));
            end
            PH_LEN:
            begin
                opa    = v_reg[m_reg];
                opb    = v_reg[m_reg];
                op_raw = 1'b1;
            end
            PH_CROSS:
            begin
                opa    = (m_reg == 2'd0) ? n_reg[jn1] : n_reg[jn2];
                opb    = (m_reg == 2'd0) ? t_reg[jn2] : t_reg[jn1];
                op_sub = (m_reg != 2'd0);
            end
            PH_HAND:
            begin
                opa = c_reg[m_reg];
                opb = b_reg[m_reg];
            end
            default:
            begin
                opa = '0;
            end
        endcase
    end

    assign term      = op_raw ? prod_reg : (prod_reg >>> FRAC_BITS);
    assign acc_base  = (m_reg == 2'd0) ? op_base : acc_reg;
    assign acc_next  = op_sub ? (acc_base - term) : (acc_base + term);
    assign last_m    = (m_reg == last_term(phase_reg));
    assign det_abs   = acc_reg[63] ? 64'(-acc_reg) : 64'(acc_reg);
    assign det_degen = det_abs <= 64'(det_thr_reg);
    assign fb_now    = ((len2_reg >> FRAC_BITS) < 64'(null_thr_reg)) || (len2_reg == 64'd0);

    assign div_num = (phase_reg == PH_TNUM) ? acc_reg : 64'($signed(v_reg[jj]));
    assign div_den = (phase_reg == PH_TNUM) ? det_reg : $signed({32'd0, len_reg});

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        m_next     = m_reg;
        case (state_reg)
            ST_IDLE:
            begin
                k_next = 2'd0;
                if (in_accept)
                begin
                    case (in_req)
                        REQ_TRI:
                        begin
                            if (ia_ok && ib_ok && ic_ok)
                            begin
                                state_next = ST_ARD;
                            end
                        end
                        REQ_FIN:
                        begin
                            if (ia_ok)
                            begin
                                state_next = ST_ARD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ARD:
            begin
                state_next = ST_ACAP;
            end
            ST_ACAP:
            begin
                if (req_reg == REQ_TRI)
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_ARD;
                    end
                end
                else
                begin
                    phase_next = PH_DOT;
                    j_next     = 3'd0;
                    m_next     = 2'd0;
                    state_next = ST_MUL;
                end
            end
            ST_DIFF:
            begin
                phase_next = PH_DET;
                j_next     = 3'd0;
                m_next     = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_m)
                begin
                    state_next = ST_ELEM;
                end
                else
                begin
                    m_next     = m_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_ELEM:
            begin
                m_next = 2'd0;
                case (phase_reg)
                    PH_DET:
                    begin
                        if (det_degen)
                        begin
                            k_next     = 2'd0;
                            state_next = ST_SRD;
                        end
                        else
                        begin
                            phase_next = PH_TNUM;
                            j_next     = 3'd0;
                            state_next = ST_MUL;
                        end
                    end
                    PH_TNUM:
                    begin
                        state_next = ST_DIVS;
                    end
                    PH_DOT:
                    begin
                        phase_next = PH_VEC;
                        j_next     = 3'd0;
                        state_next = ST_MUL;
                    end
                    PH_VEC:
                    begin
                        if (j_reg == 3'd2)
                        begin
                            phase_next = PH_LEN;
                            j_next     = 3'd0;
                        end
                        else
                        begin
                            j_next = j_reg + 3'd1;
                        end
                        state_next = ST_MUL;
                    end
                    PH_LEN:
                    begin
                        state_next = ST_SQRT;
                    end
                    PH_CROSS:
                    begin
                        if (j_reg == 3'd2)
                        begin
                            phase_next = PH_HAND;
                            j_next     = 3'd0;
                        end
                        else
                        begin
                            j_next = j_reg + 3'd1;
                        end
                        state_next = ST_MUL;
                    end
                    PH_HAND:
                    begin
                        state_next = ST_EMIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_DIVS:
            begin
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    m_next = 2'd0;
                    if (phase_reg == PH_TNUM)
                    begin
                        if (j_reg == 3'd5)
                        begin
                            k_next     = 2'd0;
                            state_next = ST_SRD;
                        end
                        else
                        begin
                            j_next     = j_reg + 3'd1;
                            state_next = ST_MUL;
                        end
                    end
                    else if (j_reg == 3'd2)
                    begin
                        phase_next = PH_CROSS;
                        j_next     = 3'd0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        j_next     = j_reg + 3'd1;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_SQRT:
            begin
                state_next = ST_SQRTW;
            end
            ST_SQRTW:
            begin
                if (sqrt_stat.done)
                begin
                    j_next = 3'd0;
                    m_next = 2'd0;
                    if (fb_now)
                    begin
                        phase_next = PH_CROSS;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        phase_next = PH_RES;
                        state_next = ST_DIVS;
                    end
                end
            end
            ST_SRD:
            begin
                state_next = ST_SCAP;
            end
            ST_SCAP:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = ST_SRD;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        div_start     = (state_reg == ST_DIVS);
        sqrt_start    = (state_reg == ST_SQRT);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_DET;
            k_reg         <= '0;
            j_reg         <= '0;
            m_reg         <= '0;
            req_reg       <= REQ_NONE;
            det_thr_reg   <= 16'd1;
            null_thr_reg  <= 16'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
            m_reg     <= m_next;
            if (in_accept)
            begin
                req_reg <= in_req;
            end
            // Configuration writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DET_THR:  det_thr_reg  <= cfg_data;
                    CFG_NULL_THR: null_thr_reg <= cfg_data;
                    default:      det_thr_reg  <= det_thr_reg;
                endcase
            end
            // Output beat: load on emit, drop on handshake
            if (state_reg == ST_EMIT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_reg[0] <= in_ia;
                    idx_reg[1] <= in_ib;
                    idx_reg[2] <= in_ic;
                end
            end
            ST_ACAP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pos_reg[k_reg][i] <= attr_rdata[32*i +: 32];
                    n_reg[i]          <= attr_rdata[160 + 32*i +: 32];
                    t_reg[i]          <= sum_rdata[32*i +: 32];
                    b_reg[i]          <= sum_rdata[96 + 32*i +: 32];
                end
                tex_reg[k_reg][0] <= attr_rdata[127:96];
                tex_reg[k_reg][1] <= attr_rdata[159:128];
            end
            ST_DIFF:
            begin
                s1_reg <= sub_sat(tex_reg[1][0], tex_reg[0][0]);
                s2_reg <= sub_sat(tex_reg[2][0], tex_reg[0][0]);
                t1_reg <= sub_sat(tex_reg[1][1], tex_reg[0][1]);
                t2_reg <= sub_sat(tex_reg[2][1], tex_reg[0][1]);
                for (int i = 0; i < 3; i++)
                begin
                    q1_reg[i] <= sub_sat(pos_reg[1][i], pos_reg[0][i]);
                    q2_reg[i] <= sub_sat(pos_reg[2][i], pos_reg[0][i]);
                end
            end
            ST_MUL:
            begin
                prod_reg <= opa * opb;
            end
            ST_ACC:
            begin
                acc_reg <= acc_next;
            end
            ST_ELEM:
            begin
                case (phase_reg)
                    PH_DET:
                    begin
                        det_reg <= acc_reg;
                        if (det_degen)
                        begin
                            tg_reg[0] <= FX_ONE;
                            tg_reg[1] <= '0;
                            tg_reg[2] <= '0;
                            bt_reg[0] <= '0;
                            bt_reg[1] <= FX_ONE;
                            bt_reg[2] <= '0;
                        end
                    end
                    PH_DOT:   d_reg       <= sat32(acc_reg);
                    PH_VEC:   v_reg[jj]   <= sat32(acc_reg);
                    PH_LEN:   len2_reg    <= acc_reg;
                    PH_CROSS: c_reg[jj]   <= sat32(acc_reg);
                    default:  len_reg     <= len_reg;
                endcase
            end
            ST_DIVW:
            begin
                if (div_stat.done)
                begin
                    if (phase_reg == PH_TNUM && j_reg >= 3'd3)
                    begin
                        bt_reg[kk] <= div_quot;
                    end
                    else
                    begin
                        tg_reg[kk] <= div_quot;
                    end
                end
            end
            ST_SQRTW:
            begin
                if (sqrt_stat.done)
                begin
                    len_reg <= sqrt_root;
                    fb_reg  <= fb_now;
                    // Null tangent: x axis for the result and the handedness
                    if (fb_now)
                    begin
                        tg_reg[0] <= FX_ONE;
                        tg_reg[1] <= '0;
                        tg_reg[2] <= '0;
                        t_reg[0]  <= FX_ONE;
                        t_reg[1]  <= '0;
                        t_reg[2]  <= '0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_index_reg <= idx_reg[0];
                    out_tan_reg   <= tg_reg;
                    out_neg_reg   <= acc_reg[63];
                    out_fb_reg    <= fb_reg;
                end
            end
            default:
            begin
                len_reg <= len_reg;
            end
        endcase
    end

    // Ports
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_tan_reg[2], out_tan_reg[1], out_tan_reg[0], out_index_reg};
    assign m_axis_tuser  = {out_fb_reg, out_neg_reg};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_unit_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (div_start || sqrt_start) |-> (!div_stat.busy && !sqrt_stat.busy))
        else $error("iterative unit started while busy");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIVW))
        else $error("quotient arrived outside the wait state");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("output beat raised outside emit");

    a_fallback_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |->
        (m_axis_tdata[43:12] == FX_ONE && m_axis_tdata[107:44] == 64'd0))
        else $error("fallback result is not the x axis");

endmodule

/* hdl/mtbg_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module mtbg_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* hdl/mtbg_div.sv */
// Iterative signed fixed-point divider: floor(|num| << FRAC_BITS / |den|), capped and signed.
module mtbg_div
    import mtbg_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic        [31:0] quot,
    output unit_stat_t         stat
);

    logic [DIV_W-1:0] x_reg;
    logic [DIV_W-1:0] d_reg;
    logic [31:0]      q_reg;
    logic             neg_reg;
    logic             ovf_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [63:0]      abs_num;
    logic [63:0]      abs_den;
    logic             ge;
    logic [31:0]      capped;

    assign abs_num = num[63] ? 64'(-num) : 64'(num);
    assign abs_den = den[63] ? 64'(-den) : 64'(den);
    assign ge      = (x_reg >= d_reg);

    // Control: step count and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if ((cnt_reg == 6'(DIV_STEPS) && ge) || cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: restoring division with the divisor shifting down
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= DIV_W'(abs_num) << FRAC_BITS;
            d_reg   <= DIV_W'(abs_den) << 32;
            q_reg   <= '0;
            neg_reg <= num[63] ^ den[63];
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'(DIV_STEPS))
            begin
                // quotient of 2^32 or more saturates
                ovf_reg <= ge;
            end
            else
            begin
                if (ge)
                begin
                    x_reg <= x_reg - d_reg;
                end
                q_reg <= {q_reg[30:0], ge};
            end
            d_reg <= d_reg >> 1;
        end
    end

    // Cap at 2^31, apply sign, saturate to 32 bits
    assign capped = (ovf_reg || q_reg[31]) ? 32'h8000_0000 : q_reg;
    assign quot   = neg_reg ? 32'(-capped) : (capped[31] ? 32'h7FFF_FFFF : capped);

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* hdl/mtbg_sqrt.sv */
// Iterative integer square root of a 64-bit value, two radicand bits per cycle.
module mtbg_sqrt
    import mtbg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output unit_stat_t  stat
);

    logic [63:0] x_reg;
    logic [63:0] r_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] bit_w;
    logic [63:0] trial;
    logic        ge;

    assign bit_w = 64'd1 << {cnt_reg, 1'b0};
    assign trial = r_reg + bit_w;
    assign ge    = (x_reg >= trial);

    // Control: step count and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(SQRT_STEPS - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: digit-by-digit root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= radicand;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                x_reg <= x_reg - trial;
                r_reg <= (r_reg >> 1) + bit_w;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign root      = r_reg[31:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the mesh tangent basis generator core.
import mtbg_pkg::*;

typedef struct {
    req_t        kind;
    logic [11:0] ia;
    logic [11:0] ib;
    logic [11:0] ic;
    int          pos[3];
    int          tex[2];
    int          nrm[3];
} mesh_req_t;

typedef struct {
    logic [11:0] vtx;
    int          tan[3];
    bit          hneg;
    bit          fb;
} frame_t;

class tangent_scoreboard;
    localparam int FB = 16;
    localparam longint ONE = 64'sd1 << FB;

    int pos_mem[12288];
    int tex_mem[8192];
    int nrm_mem[12288];
    int tsum[12288];
    int bsum[12288];
    int unsigned det_thr = 1;
    int unsigned null_thr = 1;
    frame_t frames_due[$];
    int errors = 0;

    function int sat(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function longint fmul(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FB;
    endfunction

    // Truncating fixed-point quotient, magnitude capped at 2^31
    function int qdiv(longint num, longint den);
        bit neg;
        longint unsigned an, ad, q;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (an << FB) / ad;
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        return sat(neg ? -longint'(q) : longint'(q));
    endfunction

    function longint unsigned isqrt(longint unsigned x);
        longint unsigned r, bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x -= r + bt;
                r = (r >> 1) + bt;
            end else begin
                r >>= 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    function void set_threshold(logic idx, bit [15:0] v);
        if (idx == CFG_DET_THR) det_thr = 32'(v);
        else null_thr = 32'(v);
    endfunction

    function int pending();
        return frames_due.size();
    endfunction

    function void accumulate(int ia, int ib, int ic);
        int s1, s2, t1, t2, q1[3], q2[3], tg[3], bt[3];
        longint det, adet;
        s1 = sat(longint'(tex_mem[ib*2]) - tex_mem[ia*2]);
        s2 = sat(longint'(tex_mem[ic*2]) - tex_mem[ia*2]);
        t1 = sat(longint'(tex_mem[ib*2+1]) - tex_mem[ia*2+1]);
        t2 = sat(longint'(tex_mem[ic*2+1]) - tex_mem[ia*2+1]);
        for (int k = 0; k < 3; k++) begin
            q1[k] = sat(longint'(pos_mem[ib*3+k]) - pos_mem[ia*3+k]);
            q2[k] = sat(longint'(pos_mem[ic*3+k]) - pos_mem[ia*3+k]);
        end
        det = fmul(s1, t2) - fmul(s2, t1);
        adet = det < 0 ? -det : det;
        // Degenerate texture mapping: use the x and y axes
        if (adet <= longint'(det_thr)) begin
            tg = '{int'(ONE), 0, 0};
            bt = '{0, int'(ONE), 0};
        end else begin
            for (int k = 0; k < 3; k++) begin
                tg[k] = qdiv(fmul(t2, q1[k]) - fmul(t1, q2[k]), det);
                bt[k] = qdiv(fmul(s1, q2[k]) - fmul(s2, q1[k]), det);
            end
        end
        for (int k = 0; k < 3; k++) begin
            tsum[ia*3+k] = sat(longint'(tsum[ia*3+k]) + tg[k]);
            tsum[ib*3+k] = sat(longint'(tsum[ib*3+k]) + tg[k]);
            tsum[ic*3+k] = sat(longint'(tsum[ic*3+k]) + tg[k]);
            bsum[ia*3+k] = sat(longint'(bsum[ia*3+k]) + bt[k]);
            bsum[ib*3+k] = sat(longint'(bsum[ib*3+k]) + bt[k]);
            bsum[ic*3+k] = sat(longint'(bsum[ic*3+k]) + bt[k]);
        end
    endfunction

    function frame_t orthonormalize(int ia);
        frame_t f;
        int n[3], t[3], b[3], v[3], tt[3], c[3], d;
        longint unsigned len2, len;
        longint h;
        for (int k = 0; k < 3; k++) begin
            n[k] = nrm_mem[ia*3+k];
            t[k] = tsum[ia*3+k];
            b[k] = bsum[ia*3+k];
        end
        d = sat(fmul(n[0], t[0]) + fmul(n[1], t[1]) + fmul(n[2], t[2]));
        len2 = 0;
        for (int k = 0; k < 3; k++) begin
            v[k] = sat(longint'(t[k]) - fmul(n[k], d));
            len2 += longint'(v[k]) * longint'(v[k]);
        end
        len = isqrt(len2);
        f.fb = ((len2 >> FB) < null_thr) || (len == 0);
        for (int k = 0; k < 3; k++) begin
            if (f.fb) begin
                f.tan[k] = (k == 0) ? int'(ONE) : 0;
                tt[k] = f.tan[k];
            end else begin
                f.tan[k] = qdiv(v[k], longint'(len));
                tt[k] = t[k];
            end
        end
        c[0] = sat(fmul(n[1], tt[2]) - fmul(n[2], tt[1]));
        c[1] = sat(fmul(n[2], tt[0]) - fmul(n[0], tt[2]));
        c[2] = sat(fmul(n[0], tt[1]) - fmul(n[1], tt[0]));
        h = fmul(c[0], b[0]) + fmul(c[1], b[1]) + fmul(c[2], b[2]);
        f.hneg = h < 0;
        f.vtx = ia[11:0];
        return f;
    endfunction

    function void note_request(mesh_req_t r);
        int ia;
        ia = int'(r.ia);
        case (r.kind)
            REQ_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    pos_mem[ia*3+k] = r.pos[k];
                    nrm_mem[ia*3+k] = r.nrm[k];
                    tsum[ia*3+k] = 0;
                    bsum[ia*3+k] = 0;
                end
                tex_mem[ia*2] = r.tex[0];
                tex_mem[ia*2+1] = r.tex[1];
            end
            REQ_TRI: accumulate(ia, int'(r.ib), int'(r.ic));
            REQ_FIN: frames_due.insert(frames_due.size(), orthonormalize(ia));
            default: ;
        endcase
    endfunction

    function void check_frame(frame_t got);
        frame_t w;
        if (frames_due.size() == 0) begin
            $display("%0t: unexpected frame for vertex %0d", $time, got.vtx);
            errors++;
            return;
        end
        w = frames_due[0];
        frames_due.delete(0);
        if (got.vtx !== w.vtx) begin
            $display("%0t: vertex_index exp %0d got %0d", $time, w.vtx, got.vtx);
            errors++;
        end
        for (int k = 0; k < 3; k++)
            if (got.tan[k] !== w.tan[k]) begin
                $display("%0t: vertex %0d tangent[%0d] exp %h got %h",
                         $time, w.vtx, k, w.tan[k], got.tan[k]);
                errors++;
            end
        if (got.hneg !== w.hneg) begin
            $display("%0t: vertex %0d handed_negative exp %0b got %0b",
                     $time, w.vtx, w.hneg, got.hneg);
            errors++;
        end
        if (got.fb !== w.fb) begin
            $display("%0t: vertex %0d used_fallback exp %0b got %0b",
                     $time, w.vtx, w.fb, got.fb);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int LIMIT = 1500000;
    localparam int DRAIN = 400;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [295:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [111:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic         cfg_index = CFG_DET_THR;
    logic [15:0]  cfg_data = '0;

    tangent_scoreboard sb = new();
    bit   loaded[4096];
    int   loaded_list[$];
    bit   steady = 0;
    int   cycles = 0;

    mesh_tangent_basis_generator_core dut (.*);

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    // Watch both streams and stop on a hang
    always @(posedge clk) begin
        mesh_req_t r;
        frame_t f;
        cycles++;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r.kind = req_t'(s_axis_tuser);
            r.ia = s_axis_tdata[11:0];
            r.ib = s_axis_tdata[23:12];
            r.ic = s_axis_tdata[35:24];
            for (int k = 0; k < 3; k++) begin
                r.pos[k] = s_axis_tdata[36 + 32*k +: 32];
                r.nrm[k] = s_axis_tdata[196 + 32*k +: 32];
            end
            r.tex[0] = s_axis_tdata[163:132];
            r.tex[1] = s_axis_tdata[195:164];
            sb.note_request(r);
        end
        if (m_axis_tvalid && m_axis_tready) begin
            f.vtx = m_axis_tdata[11:0];
            for (int k = 0; k < 3; k++)
                f.tan[k] = m_axis_tdata[12 + 32*k +: 32];
            f.hneg = m_axis_tuser[0];
            f.fb = m_axis_tuser[1];
            sb.check_frame(f);
        end
    end

    // Result side: random stalls before each beat
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            repeat (stall) begin
                @(negedge clk);
                m_axis_tready = 0;
            end
            @(negedge clk);
            m_axis_tready = 1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    task automatic send(mesh_req_t r);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge clk);
            s_axis_tvalid = 0;
        end
        @(negedge clk);
        s_axis_tvalid = 1;
        s_axis_tuser = r.kind;
        s_axis_tdata = {4'b0, r.nrm[2], r.nrm[1], r.nrm[0], r.tex[1], r.tex[0],
                        r.pos[2], r.pos[1], r.pos[0], r.ic, r.ib, r.ia};
        do @(posedge clk); while (!s_axis_tready);
        if (r.kind == REQ_LOAD && !loaded[r.ia]) begin
            loaded[r.ia] = 1;
            loaded_list.insert(loaded_list.size(), int'(r.ia));
        end
    endtask

    task automatic settle();
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        @(negedge clk);
        s_axis_tvalid = 0;
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_threshold(idx, v);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic mesh_req_t vertex(int ia, int p0, int p1, int p2, int u, int v,
                                         int n0, int n1, int n2);
        mesh_req_t r;
        r.kind = REQ_LOAD;
        r.ia = 12'(ia);
        r.ib = 12'($urandom);
        r.ic = 12'($urandom);
        r.pos = '{p0, p1, p2};
        r.tex = '{u, v};
        r.nrm = '{n0, n1, n2};
        return r;
    endfunction

    function automatic mesh_req_t op(req_t k, int ia, int ib, int ic);
        mesh_req_t r;
        r = vertex(ia, 0, 0, 0, 0, 0, 0, 0, 0);
        r.kind = k;
        r.ib = 12'(ib);
        r.ic = 12'(ic);
        for (int j = 0; j < 3; j++) begin
            r.pos[j] = $urandom;
            r.nrm[j] = $urandom;
        end
        r.tex = '{int'($urandom), int'($urandom)};
        return r;
    endfunction

    // Plausible mesh data most of the time, raw words otherwise
    function automatic mesh_req_t random_vertex();
        int ia;
        mesh_req_t r;
        ia = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0)
            return vertex(ia, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
        r = vertex(ia, int'($urandom_range(0, 1048576)) - 524288,
                   int'($urandom_range(0, 1048576)) - 524288,
                   int'($urandom_range(0, 1048576)) - 524288,
                   $urandom_range(0, 65536), $urandom_range(0, 65536),
                   int'($urandom_range(0, 131072)) - 65536,
                   int'($urandom_range(0, 131072)) - 65536,
                   int'($urandom_range(0, 131072)) - 65536);
        return r;
    endfunction

    function automatic int pick();
        return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
    endfunction

    initial begin
        int sel;
        logic [15:0] det_set[4];
        logic [15:0] null_set[4];
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: simple quad, extremes, degenerate and null cases
        send(vertex(0, 0, 0, 0, 0, 0, 0, 0, 65536));
        send(vertex(1, 65536, 0, 0, 65536, 0, 0, 0, 65536));
        send(vertex(2, 0, 65536, 0, 0, 65536, 0, 0, 65536));
        send(vertex(3, 65536, 65536, 0, 0, 65536, 0, 0, -65536));
        send(op(REQ_TRI, 0, 1, 2));
        send(op(REQ_TRI, 1, 3, 2));
        send(op(REQ_TRI, 0, 0, 1));
        send(op(REQ_FIN, 0, 0, 0));
        send(op(REQ_FIN, 3, 0, 0));
        send(vertex(4095, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
        send(vertex(4094, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                    32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000));
        send(vertex(2048, 0, 0, 0, 0, 0, 32'hffffffff, 0, 0));
        send(op(REQ_TRI, 4095, 4094, 0));
        send(op(REQ_TRI, 4094, 4095, 2048));
        send(op(REQ_TRI, 4095, 4094, 1));
        send(op(REQ_FIN, 4095, 0, 0));
        send(op(REQ_FIN, 4094, 0, 0));
        send(op(REQ_FIN, 2048, 0, 0));
        send(op(REQ_NONE, 4095, 4095, 4095));
        send(op(REQ_FIN, 1, 0, 0));
        send(op(REQ_FIN, 2, 0, 0));

        // Random phases, each under its own thresholds
        det_set = '{16'd0, 16'hffff, 16'($urandom), 16'd1};
        null_set = '{16'hffff, 16'd0, 16'($urandom), 16'd1};
        for (int ph = 0; ph < 4; ph++) begin
            @(negedge clk);
            s_axis_tvalid = 0;
            settle();
            write_reg(CFG_DET_THR, det_set[ph]);
            write_reg(CFG_NULL_THR, null_set[ph]);
            for (int i = 0; i < 200; i++) begin
                if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
                sel = $urandom_range(0, 99);
                if (sel < 30) send(random_vertex());
                else if (sel < 70) send(op(REQ_TRI, pick(), pick(), pick()));
                else if (sel < 95) send(op(REQ_FIN, pick(), 0, 0));
                else send(op(REQ_NONE, $urandom, $urandom, $urandom));
            end
        end

        // Drain and report
        @(negedge clk);
        s_axis_tvalid = 0;
        settle();
        if (sb.pending() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
